FILE: hdl/gus_pkg.sv
// ----------------------------------------------------------------------------
// gus_pkg
// Shared codes, types and character-class helpers for the URI splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gus_pkg;

    localparam int PhaseW  = 3;
    localparam int CountW  = 4;
    localparam int RoleW   = 2;
    localparam int PrefixLen = 9;

    localparam logic [PhaseW-1:0] PH_PREFIX     = 3'd0;
    localparam logic [PhaseW-1:0] PH_HOST_FIRST = 3'd1;
    localparam logic [PhaseW-1:0] PH_HOST       = 3'd2;
    localparam logic [PhaseW-1:0] PH_PORT_FIRST = 3'd3;
    localparam logic [PhaseW-1:0] PH_PORT       = 3'd4;
    localparam logic [PhaseW-1:0] PH_PATH       = 3'd5;
    localparam logic [PhaseW-1:0] PH_REJECT     = 3'd6;

    localparam logic [RoleW-1:0] ROLE_SCHEME  = 2'd0;
    localparam logic [RoleW-1:0] ROLE_ADDRESS = 2'd1;
    localparam logic [RoleW-1:0] ROLE_PATH    = 2'd2;
    localparam logic [RoleW-1:0] ROLE_REJECT  = 2'd3;

    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [CountW-1:0] prefix_count;
    } gus_state_t;

    typedef struct packed {
        logic [RoleW-1:0] role;
        logic             done_res;
        logic             accepted;
    } gus_result_t;

    // "gemini://"
    function automatic logic [7:0] scheme_char(input logic [CountW-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h67;  // g
            4'd1:    c = 8'h65;  // e
            4'd2:    c = 8'h6D;  // m
            4'd3:    c = 8'h69;  // i
            4'd4:    c = 8'h6E;  // n
            4'd5:    c = 8'h69;  // i
            4'd6:    c = 8'h3A;  // :
            4'd7:    c = 8'h2F;  // /
            4'd8:    c = 8'h2F;  // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic host_char_ok(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_DOT) || (c == CH_DASH);
    endfunction

endpackage

FILE: hdl/gus_step.sv
// ----------------------------------------------------------------------------
// gus_step
// Per-byte classifier: tags one byte and computes the next parse state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gus_step (
    input  gus_pkg::gus_state_t  cur,
    input  logic [7:0]           byte_in,
    input  logic                 is_last,
    output gus_pkg::gus_state_t  nxt,
    output gus_pkg::gus_result_t res
);
    import gus_pkg::*;

    logic [RoleW-1:0]  role;
    logic [PhaseW-1:0] phase_next;
    logic [CountW-1:0] count_next;
    logic              prefix_hit;

    // out-of-range count never matches
    assign prefix_hit = (cur.prefix_count < CountW'(PrefixLen)) &&
                        (byte_in == scheme_char(cur.prefix_count));

    always_comb begin
        role       = ROLE_REJECT;
        phase_next = PH_REJECT;
        count_next = cur.prefix_count;
        unique case (cur.phase)
            PH_PREFIX: begin
                if (prefix_hit) begin
                    role       = ROLE_SCHEME;
                    count_next = cur.prefix_count + 4'd1;
                    phase_next = (count_next >= CountW'(PrefixLen)) ? PH_HOST_FIRST
                                                                     : PH_PREFIX;
                end
            end
            PH_HOST_FIRST: begin
                if (host_char_ok(byte_in)) begin
                    role       = ROLE_ADDRESS;
                    phase_next = PH_HOST;
                end
            end
            PH_HOST: begin
                if (byte_in == CH_SLASH) begin
                    role       = ROLE_PATH;
                    phase_next = PH_PATH;
                end else if (byte_in == CH_COLON) begin
                    role       = ROLE_ADDRESS;
                    phase_next = PH_PORT_FIRST;
                end else if (byte_in != CH_AT && host_char_ok(byte_in)) begin
                    role       = ROLE_ADDRESS;
                    phase_next = PH_HOST;
                end
            end
            PH_PORT_FIRST: begin
                if (is_digit(byte_in)) begin
                    role       = ROLE_ADDRESS;
                    phase_next = PH_PORT;
                end
            end
            PH_PORT: begin
                if (byte_in == CH_SLASH) begin
                    role       = ROLE_PATH;
                    phase_next = PH_PATH;
                end else if (is_digit(byte_in)) begin
                    role       = ROLE_ADDRESS;
                    phase_next = PH_PORT;
                end
            end
            PH_PATH: begin
                role       = ROLE_PATH;
                phase_next = PH_PATH;
            end
            default: begin
                // rejected, and unused codes
            end
        endcase
    end

    always_comb begin
        res.role     = role;
        res.done_res = is_last;
        res.accepted = is_last && (phase_next == PH_HOST || phase_next == PH_PORT ||
                                   phase_next == PH_PATH);
        if (is_last) begin
            nxt.phase        = PH_PREFIX;
            nxt.prefix_count = '0;
        end else begin
            nxt.phase        = phase_next;
            nxt.prefix_count = count_next;
        end
    end

endmodule

FILE: hdl/gemini_uri_splitter_unit.sv
// ----------------------------------------------------------------------------
// gemini_uri_splitter_unit
// Streaming gemini:// URI checker that tags each byte with its role.
// ----------------------------------------------------------------------------
// One URI byte per request on the s_ side, s_tlast on its final byte. Each
// request yields exactly one result, registered in the cycle after it is
// taken: m_tdata[1:0] is the role (scheme, address, path, rejected), m_tlast
// marks the final byte and m_tuser[0] then says whether the URI was well
// formed. A request is taken every cycle while the result register is empty
// or being drained; the only loop is the registered parse-state update, so
// throughput is one byte per clock. Tags of a rejected URI are to be dropped.
`timescale 1ns / 1ps

module gemini_uri_splitter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] role, [7:2] zero
    output logic       m_tlast,   // done_res
    output logic [0:0] m_tuser    // [0] accepted
);
    import gus_pkg::*;

    gus_state_t  state_reg, state_next;
    gus_result_t res_reg, res_next;
    logic        m_valid_reg;
    logic        s_acc;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    gus_step u_step (
        .cur     (state_reg),
        .byte_in (s_tdata),
        .is_last (s_tlast),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_PREFIX;
            state_reg.prefix_count <= '0;
            m_valid_reg            <= 1'b0;
        end else begin
            if (s_acc) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {6'd0, res_reg.role};
    assign m_tlast    = res_reg.done_res;
    assign m_tuser[0] = res_reg.accepted;

    // end of URI always returns the parser to the prefix state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (state_reg.phase == PH_PREFIX &&
                                state_reg.prefix_count == '0))
        else $error("parser not restarted after last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.accepted) |-> (res_reg.done_res &&
                                               res_reg.role != ROLE_REJECT))
        else $error("accept flagged on non-final or rejected byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.prefix_count <= CountW'(PrefixLen))
        else $error("prefix count out of range");

    // a prefix mismatch may park the count short of full in the reject phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != PH_PREFIX && state_reg.phase != PH_REJECT) |->
        (state_reg.prefix_count == CountW'(PrefixLen)))
        else $error("left prefix phase without full prefix");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && !s_acc) |=> m_valid_reg)
        else $error("result dropped while stalled");

endmodule
